// File: sv/ppmrc_pkg.sv
// ----------------------------------------------------------------------------
// ppmrc_pkg
// Shared types, constants and helpers for the RC PPM channel decoder.
// ----------------------------------------------------------------------------
package ppmrc_pkg;

	localparam int PPMRC_NUM_CHANNELS = 8;

	localparam int STAMP_W = 16;
	localparam int GAP_W   = 16;
	localparam int PULSE_W = 15;
	localparam int CH_W    = 8;
	localparam int OVR_W   = 16;
	localparam int VCNT_W  = 4;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [STAMP_W-1:0] TIMER_TOP_RST = 16'd40000;
	localparam logic [GAP_W-1:0]   SYNC_GAP_RST  = 16'd8000;
	localparam logic [PULSE_W-1:0] MIN_PULSE_RST = 15'd800;
	localparam logic [PULSE_W-1:0] MAX_PULSE_RST = 15'd2200;

	typedef enum logic [1:0] {
		OP_CAPTURE   = 2'd0,
		OP_READ      = 2'd1,
		OP_SET_OVR   = 2'd2,
		OP_CLEAR_OVR = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TIMER_TOP = 2'd0,
		CFG_SYNC_GAP  = 2'd1,
		CFG_MIN_PULSE = 2'd2,
		CFG_MAX_PULSE = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [STAMP_W-1:0] timer_top;
		logic [GAP_W-1:0]   sync_gap;
		logic [PULSE_W-1:0] min_pulse;
		logic [PULSE_W-1:0] max_pulse;
	} cfg_t;

	typedef struct packed {
		op_t                     op;
		logic [STAMP_W-1:0]      capture_time;
		logic [CH_W-1:0]         channel;
		logic signed [OVR_W-1:0] override_value;
	} item_t;

	typedef struct packed {
		logic [PULSE_W-1:0] pulse_us;
		logic [VCNT_W-1:0]  valid_count;
		logic               accepted;
	} result_t;

	// when the bounds cross, the max bound wins for widths above it and the min bound for the rest
	function automatic logic [PULSE_W-1:0] clamp_width(
		input logic [PULSE_W-1:0] p,
		input logic [PULSE_W-1:0] lo,
		input logic [PULSE_W-1:0] hi
	);
		logic [PULSE_W-1:0] r;
		if (p > hi)
			r = hi;
		else if (p < lo)
			r = lo;
		else
			r = p;
		return r;
	endfunction

endpackage

// File: sv/ppm_rc_channel_decoder.sv
// ----------------------------------------------------------------------------
// ppm_rc_channel_decoder
// RC PPM decoder top level: input register, decode state, result register.
// ----------------------------------------------------------------------------
// One word is taken per clock while the input is not stalled. An accepted
// word is held in the input register while the decode logic reads and
// updates the channel state; its result then lands in the output register
// once that slot is empty or draining, and is taken at a clock edge where
// out_ready is high. The output register parts the two sides, so one more
// word is taken while a result waits; the input stalls only when both the
// input register and the output register are full and out_ready is low.
// Channel slots and overrides live in flip-flops cleared by reset.
module ppm_rc_channel_decoder
	import ppmrc_pkg::*;
#(
	parameter int NUM_CHANNELS = PPMRC_NUM_CHANNELS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           op,
	input  logic [STAMP_W-1:0]   capture_time,
	input  logic [CH_W-1:0]      channel,
	input  logic signed [OVR_W-1:0] override_value,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [PULSE_W-1:0]   pulse_us,
	output logic [VCNT_W-1:0]    valid_count,
	output logic                 accepted
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	result_t res;
	result_t res_q;
	logic    out_valid_q;

	ppmrc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ppmrc_state #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// move the held word on when the result slot is empty or draining
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.op             <= op_t'(op);
			item_s1.capture_time   <= capture_time;
			item_s1.channel        <= channel;
			item_s1.override_value <= override_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res;
	end

	assign out_valid   = out_valid_q;
	assign pulse_us    = res_q.pulse_us;
	assign valid_count = res_q.valid_count;
	assign accepted    = res_q.accepted;

`ifndef SYNTHESIS
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid_q && !out_ready)
		else $error("input stalled without a blocked result");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !advance)
		else $error("pending result overwritten");

	a_accept_only_set: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.op != OP_SET_OVR |=> !accepted)
		else $error("accepted flag raised outside set override");
`endif

endmodule

// File: sv/ppmrc_cfg.sv
// ----------------------------------------------------------------------------
// ppmrc_cfg
// Configuration register file: timer top, sync gap and clamp bounds.
// ----------------------------------------------------------------------------
module ppmrc_cfg
	import ppmrc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timer_top <= TIMER_TOP_RST;
			cfg_q.sync_gap  <= SYNC_GAP_RST;
			cfg_q.min_pulse <= MIN_PULSE_RST;
			cfg_q.max_pulse <= MAX_PULSE_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_TIMER_TOP: cfg_q.timer_top <= cfg_data;
				CFG_SYNC_GAP:  cfg_q.sync_gap  <= cfg_data;
				CFG_MIN_PULSE: cfg_q.min_pulse <= cfg_data[PULSE_W-1:0];
				CFG_MAX_PULSE: cfg_q.max_pulse <= cfg_data[PULSE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: sv/ppmrc_state.sv
// ----------------------------------------------------------------------------
// ppmrc_state
// Channel state and per-word decode: gap measurement, slot fill, reads with
// clamp and override, override table updates.
// ----------------------------------------------------------------------------
module ppmrc_state
	import ppmrc_pkg::*;
#(
	parameter int NUM_CHANNELS = PPMRC_NUM_CHANNELS
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t res
);

	localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int CNT_W = $clog2(NUM_CHANNELS + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(NUM_CHANNELS);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
	localparam logic [CH_W:0]    CH_LIMIT = (CH_W + 1)'(NUM_CHANNELS);

	logic [GAP_W-1:0]   width_q [NUM_CHANNELS];
	logic [PULSE_W-1:0] ovr_q   [NUM_CHANNELS];
	logic [STAMP_W-1:0] prev_stamp_q;
	logic [CNT_W-1:0]   idx_q;
	logic [CNT_W-1:0]   cnt_q;

	logic               ch_ok;
	logic [IDX_W-1:0]   rd_idx;
	logic [IDX_W-1:0]   wr_idx;
	logic [GAP_W-1:0]   gap;
	logic               is_sync;
	logic               slot_free;
	logic [PULSE_W-1:0] clamped;
	logic [PULSE_W-1:0] ovr_rd;
	logic               set_ok;
	logic               set_nonzero;
	logic [CNT_W+VCNT_W-1:0] cnt_ext;
	logic               any_ovr;

	always_comb begin
		ch_ok     = {1'b0, item.channel} < CH_LIMIT;
		rd_idx    = ch_ok ? item.channel[IDX_W-1:0] : '0;
		wr_idx    = idx_q[IDX_W-1:0];
		slot_free = idx_q < CNT_FULL;
		// wrap at timer top, kept to 16 bits
		if (item.capture_time < prev_stamp_q)
			gap = item.capture_time + cfg.timer_top - prev_stamp_q;
		else
			gap = item.capture_time - prev_stamp_q;
		is_sync     = gap > cfg.sync_gap;
		clamped     = clamp_width(width_q[rd_idx][GAP_W-1:1], cfg.min_pulse, cfg.max_pulse);
		ovr_rd      = ovr_q[rd_idx];
		set_ok      = !item.override_value[OVR_W-1] && ch_ok;
		set_nonzero = item.override_value[OVR_W-2:0] != '0;
		cnt_ext     = {{VCNT_W{1'b0}}, cnt_q};

		res.pulse_us    = '0;
		res.valid_count = cnt_ext[VCNT_W-1:0];
		res.accepted    = 1'b0;
		if (item.op == OP_READ && ch_ok)
			res.pulse_us = (ovr_rd != '0) ? ovr_rd : clamped;
		if (item.op == OP_SET_OVR)
			res.accepted = set_ok && set_nonzero;

		any_ovr = 1'b0;
		for (int i = 0; i < NUM_CHANNELS; i++)
			any_ovr = any_ovr | (ovr_q[i] != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				width_q[i] <= '0;
				ovr_q[i]   <= '0;
			end
			prev_stamp_q <= '0;
			idx_q        <= '0;
			cnt_q        <= '0;
		end else if (fire) begin
			unique case (item.op)
				OP_CAPTURE: begin
					prev_stamp_q <= item.capture_time;
					if (is_sync) begin
						idx_q <= '0;
					end else if (slot_free) begin
						width_q[wr_idx] <= gap;
						idx_q           <= idx_q + CNT_ONE;
						if (idx_q + CNT_ONE == CNT_FULL)
							cnt_q <= CNT_FULL;
					end
				end
				OP_READ: begin
					if (ch_ok)
						cnt_q <= '0;
				end
				OP_SET_OVR: begin
					if (set_ok) begin
						ovr_q[rd_idx] <= item.override_value[PULSE_W-1:0];
						if (set_nonzero)
							cnt_q <= CNT_ONE;
					end
				end
				OP_CLEAR_OVR: begin
					for (int i = 0; i < NUM_CHANNELS; i++)
						ovr_q[i] <= '0;
				end
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= CNT_FULL)
		else $error("channel index past last slot");

	a_cnt_values: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 || cnt_q == CNT_ONE || cnt_q == CNT_FULL)
		else $error("valid count holds an impossible value");

	a_clear_all: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.op == OP_CLEAR_OVR |=> !any_ovr)
		else $error("override table not cleared");

	a_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.op == OP_READ && ch_ok |=> cnt_q == '0)
		else $error("in-range read left valid count set");
`endif

endmodule
